[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DIPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DIPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/dipc_pkg.sv]
// Package for the decimal integer parse checker: widths, character codes, types.
package dipc_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAG_BITS   = VALUE_BITS - 1;
    localparam int CHAR_BITS  = 8;
    localparam int DIGIT_BITS = 4;
    localparam int PROD_BITS  = MAG_BITS + DIGIT_BITS;

    localparam logic [MAG_BITS-1:0]   MAX_MAG = '1;
    localparam logic [DIGIT_BITS-1:0] RADIX   = 4'd10;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0D;

    typedef enum logic [5:0] {
        PH_LEAD   = 6'b000001,
        PH_SIGN   = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_TRAIL  = 6'b010000,
        PH_BAD    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_code;
        logic                 char_present;
        logic                 last;
    } beat_t;

    typedef struct packed {
        logic                         is_valid;
        logic signed [VALUE_BITS-1:0] parsed_value;
    } result_t;

endpackage

[hdl/dipc_in_stage.sv]
// Input register: holds one accepted character beat until the parser takes it.
module dipc_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  dipc_pkg::beat_t beat_in,
    input  logic            consume,
    output logic            held_valid,
    output dipc_pkg::beat_t held_beat
);
    import dipc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  take;

    assign s_tready   = !valid_reg || consume;
    assign take       = s_tvalid && s_tready;
    assign valid_next = take ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= beat_in;
        end
    end

    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

endmodule

[hdl/dipc_parser.sv]
// Field parser: phase, sign, magnitude and overflow state, one character per step.
module dipc_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              consume,
    input  dipc_pkg::beat_t   beat,
    output dipc_pkg::result_t result
);
    import dipc_pkg::*;

    phase_t              phase_reg, phase_next, phase_chr;
    logic                neg_reg, neg_next, neg_chr;
    logic [MAG_BITS-1:0] mag_reg, mag_next, mag_chr;
    logic                ovf_reg, ovf_next, ovf_chr;

    logic                  blank;
    logic                  digit;
    logic                  minus;
    logic [DIGIT_BITS-1:0] dval;
    logic [PROD_BITS-1:0]  prod;
    logic                  prod_big;
    logic                  ok;
    logic [VALUE_BITS-1:0] mag_ext;

    logic [CHAR_BITS-1:0] c;

    assign c     = beat.char_code;
    assign blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    assign digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign minus = (c == CHAR_MINUS);
    assign dval  = digit ? DIGIT_BITS'(c - CHAR_ZERO) : '0;

    // mag*10 + d against the largest positive value
    assign prod     = PROD_BITS'(mag_reg) * PROD_BITS'(RADIX) + PROD_BITS'(dval);
    assign prod_big = prod > PROD_BITS'(MAX_MAG);

    always_comb
    begin
        phase_chr = phase_reg;
        neg_chr   = neg_reg;
        mag_chr   = mag_reg;
        ovf_chr   = ovf_reg;
        if (beat.char_present)
        begin
            unique case (phase_reg) inside
                PH_LEAD, PH_SIGN:
                begin
                    if (blank)
                    begin
                        if (phase_reg == PH_SIGN)
                        begin
                            phase_chr = PH_BAD;
                        end
                    end
                    else if (minus && phase_reg == PH_LEAD)
                    begin
                        neg_chr   = 1'b1;
                        phase_chr = PH_SIGN;
                    end
                    else if (c == CHAR_ZERO)
                    begin
                        phase_chr = PH_ZERO;
                    end
                    else if (digit)
                    begin
                        mag_chr   = MAG_BITS'(dval);
                        phase_chr = PH_DIGITS;
                    end
                    else
                    begin
                        phase_chr = PH_BAD;
                    end
                end
                PH_ZERO:
                begin
                    phase_chr = blank ? PH_TRAIL : PH_BAD;
                end
                PH_DIGITS:
                begin
                    if (blank)
                    begin
                        phase_chr = PH_TRAIL;
                    end
                    else if (digit)
                    begin
                        if (ovf_reg || prod_big)
                        begin
                            ovf_chr = 1'b1;
                        end
                        else
                        begin
                            mag_chr = prod[MAG_BITS-1:0];
                        end
                    end
                    else
                    begin
                        phase_chr = PH_BAD;
                    end
                end
                PH_TRAIL:
                begin
                    if (!blank)
                    begin
                        phase_chr = PH_BAD;
                    end
                end
                default:
                begin
                    phase_chr = PH_BAD;
                end
            endcase
        end
    end

    assign ok = ((phase_chr == PH_ZERO) || (phase_chr == PH_DIGITS) ||
                 (phase_chr == PH_TRAIL)) && !ovf_chr;
    assign mag_ext = VALUE_BITS'(mag_chr);

    always_comb
    begin
        result.is_valid     = ok;
        result.parsed_value = '0;
        if (ok)
        begin
            result.parsed_value = neg_chr ? -mag_ext : mag_ext;
        end
    end

    // a closing beat returns everything to the start of a new field
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        if (consume)
        begin
            if (beat.last)
            begin
                phase_next = PH_LEAD;
                neg_next   = 1'b0;
                mag_next   = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                phase_next = phase_chr;
                neg_next   = neg_chr;
                mag_next   = mag_chr;
                ovf_next   = ovf_chr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[hdl/dipc_out_stage.sv]
// Result register: one pending result beat toward the receiver.
module dipc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dipc_pkg::result_t result,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dipc_pkg::result_t held
);
    import dipc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign valid_next = load ? 1'b1 : ((valid_reg && m_tready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign held     = res_reg;

endmodule

[hdl/decimal_integer_parse_check_core.sv]
// Top level of the decimal integer parse checker.
// Usage:
//   The slave stream carries one text character per beat: s_tdata is the ASCII
//   code, s_tuser is 1 when a character is present (0 for an empty marker beat),
//   s_tlast closes the field. Leading and trailing whitespace is skipped, one
//   leading minus is allowed, a multi-digit number may not start with zero.
//   Each closed field yields one beat on the master stream: m_tuser says whether
//   the field was a valid in-range integer, m_tdata holds its signed value
//   (zero when invalid). Non-last beats produce nothing on the master side.
//   Throughput: one character beat per cycle, sustained while the result register
//   is free or being taken. Result path: an accepted closing beat is held in the
//   input register; the parser step then loads its result into the result register.
//   Receiver stall: the result register holds its beat; character beats keep
//   flowing through the parser, and only a closing beat waits in the input
//   register, which then drops s_tready until the result is taken.
//   Reset (rst_n low, async): parser returns to the leading-whitespace phase,
//   both registers empty; s_tready is high right after reset.
module decimal_integer_parse_check_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dipc_pkg::CHAR_BITS-1:0]  s_tdata,   // [7:0] char_code
    input  logic                            s_tuser,   // [0] char_present
    input  logic                            s_tlast,   // last
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dipc_pkg::VALUE_BITS-1:0] m_tdata,   // [31:0] parsed_value
    output logic                            m_tuser    // [0] is_valid
);
    import dipc_pkg::*;

    beat_t   beat_in;
    beat_t   held_beat;
    logic    held_valid;
    logic    consume;
    logic    load;
    result_t step_res;
    result_t out_res;

    assign beat_in.char_code    = s_tdata;
    assign beat_in.char_present = s_tuser;
    assign beat_in.last         = s_tlast;

    // non-closing beats always advance; a closing beat needs a free result slot
    assign consume = held_valid && (!held_beat.last || !m_tvalid || m_tready);
    assign load    = consume && held_beat.last;

    dipc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .beat_in    (beat_in),
        .consume    (consume),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    dipc_parser u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .consume (consume),
        .beat    (held_beat),
        .result  (step_res)
    );

    dipc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (step_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .held     (out_res)
    );

    assign m_tdata = out_res.parsed_value;
    assign m_tuser = out_res.is_valid;

endmodule

[hdl/dipc_checker.sv]
// Port-level checker for the parse checker core, bound to the top level.
`include "assert_macros.svh"

module dipc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    `DIPC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `DIPC_ASSERT_IMP(a_bad_is_zero, m_tvalid && !m_tuser, m_tdata == 32'h0)
    `DIPC_ASSERT_IMP(a_no_min_int, m_tvalid && m_tuser, m_tdata != 32'h80000000)
    `DIPC_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)
    `DIPC_ASSERT_IMP(a_result_latency, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast, 2))

endmodule

bind decimal_integer_parse_check_core dipc_checker u_dipc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
